/* rtl/core/m3i_pkg.sv */
// Shared constants, types and helpers for the 3x3 matrix inverse block.
// No dependencies; imported by every module of the block.
`default_nettype none

package m3i_pkg;

    localparam int IN_WIDTH_DEF  = 16;
    localparam int OUT_WIDTH_DEF = 32;
    localparam int IN_FRAC       = 12;
    localparam int OUT_FRAC      = 16;
    localparam int FRAC_SHIFT    = IN_FRAC + OUT_FRAC;
    localparam int QUEUE_DEPTH   = 2;

    // valid and classification of one transaction between front and back
    typedef struct packed {
        logic valid;
        logic singular;
    } job_ctl_t;

    // signed cofactor width for element width iw
    function automatic int m3i_cof_width(input int iw);
        return 2 * iw + 1;
    endfunction

    // signed determinant width for element width iw
    function automatic int m3i_det_width(input int iw);
        return 3 * iw + 3;
    endfunction

    // start-to-done distance in cycles for output width ow
    function automatic int m3i_latency(input int ow);
        return ow + 8;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/matrix3_inverse_top.sv */
// Top level of the 3x3 matrix inverse: front, queue and nine dividers.
// Depends on m3i_pkg, m3i_front, m3i_queue and m3i_div.
//
// Usage:
//   Input: present nine signed Q4.12 elements (row-major) with start high;
//   the matrix is taken at a rising edge where start is high and busy low.
//   Output: done pulses for one cycle with the nine Q16.16 inverse entries
//   and singular; the receiver cannot stall, results must be taken then.
// Pipeline: from the start edge to the done edge lie five front stages,
//   one queue stage and one divider stage per quotient bit plus capture
//   and output registers.
// Throughput: one matrix per cycle; every divider stage resolves one bit of
//   all nine quotients, so a new matrix enters each cycle.
// busy is high only when the front-to-back queue is full.
// Singular matrices give singular = 1 and all-zero entries.
// Reset: asynchronous, active low; clears every valid flag, drops all
//   transactions in flight and leaves done low.
`default_nettype none

module matrix3_inverse_top
    import m3i_pkg::*;
#(
    parameter int IN_WIDTH  = IN_WIDTH_DEF,
    parameter int OUT_WIDTH = OUT_WIDTH_DEF
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire logic signed [IN_WIDTH-1:0]  in_r0c0,
    input  wire logic signed [IN_WIDTH-1:0]  in_r0c1,
    input  wire logic signed [IN_WIDTH-1:0]  in_r0c2,
    input  wire logic signed [IN_WIDTH-1:0]  in_r1c0,
    input  wire logic signed [IN_WIDTH-1:0]  in_r1c1,
    input  wire logic signed [IN_WIDTH-1:0]  in_r1c2,
    input  wire logic signed [IN_WIDTH-1:0]  in_r2c0,
    input  wire logic signed [IN_WIDTH-1:0]  in_r2c1,
    input  wire logic signed [IN_WIDTH-1:0]  in_r2c2,
    output logic                         done,
    output logic signed [OUT_WIDTH-1:0]  inv_r0c0,
    output logic signed [OUT_WIDTH-1:0]  inv_r0c1,
    output logic signed [OUT_WIDTH-1:0]  inv_r0c2,
    output logic signed [OUT_WIDTH-1:0]  inv_r1c0,
    output logic signed [OUT_WIDTH-1:0]  inv_r1c1,
    output logic signed [OUT_WIDTH-1:0]  inv_r1c2,
    output logic signed [OUT_WIDTH-1:0]  inv_r2c0,
    output logic signed [OUT_WIDTH-1:0]  inv_r2c1,
    output logic signed [OUT_WIDTH-1:0]  inv_r2c2,
    output logic                         singular
);

    localparam int CW = m3i_cof_width(IN_WIDTH);
    localparam int DW = m3i_det_width(IN_WIDTH);
    localparam int QW = 9 * CW + 9 + DW + 2;

    job_ctl_t           front_ctl;
    logic [8:0][CW-1:0] f_cmag, q_cmag;
    logic [8:0]         f_cneg, q_cneg;
    logic [DW-1:0]      f_dmag, q_dmag;
    logic               f_dneg, q_dneg, q_sing, q_valid;
    logic [QW-1:0]      q_data;
    job_ctl_t           back_ctl;
    job_ctl_t           div_ctl [9];
    logic [OUT_WIDTH-1:0] quo [9];
    logic [8:0]         div_vld, div_sing;

    m3i_front #(
        .IN_WIDTH (IN_WIDTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (start && !busy),
        .a00    (in_r0c0),
        .a01    (in_r0c1),
        .a02    (in_r0c2),
        .a10    (in_r1c0),
        .a11    (in_r1c1),
        .a12    (in_r1c2),
        .a20    (in_r2c0),
        .a21    (in_r2c1),
        .a22    (in_r2c2),
        .ctl    (front_ctl),
        .cmag   (f_cmag),
        .cneg   (f_cneg),
        .dmag   (f_dmag),
        .dneg   (f_dneg)
    );

    m3i_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_ctl.valid),
        .in_data   ({front_ctl.singular, f_dneg, f_dmag, f_cneg, f_cmag}),
        .full      (busy),
        .out_valid (q_valid),
        .out_data  (q_data)
    );

    assign {q_sing, q_dneg, q_dmag, q_cneg, q_cmag} = q_data;
    assign back_ctl.valid    = q_valid;
    assign back_ctl.singular = q_sing;

    for (genvar k = 0; k < 9; k++)
    begin : g_div
        m3i_div #(
            .CW        (CW),
            .DW        (DW),
            .OUT_WIDTH (OUT_WIDTH)
        ) u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_ctl  (back_ctl),
            .cmag    (q_cmag[k]),
            .dmag    (q_dmag),
            .neg     (q_cneg[k] ^ q_dneg),
            .out_ctl (div_ctl[k]),
            .quo     (quo[k])
        );
        assign div_vld[k]  = div_ctl[k].valid;
        assign div_sing[k] = div_ctl[k].singular;
    end

    assign done     = &div_vld;
    assign singular = &div_sing;
    assign inv_r0c0 = quo[0];
    assign inv_r0c1 = quo[1];
    assign inv_r0c2 = quo[2];
    assign inv_r1c0 = quo[3];
    assign inv_r1c1 = quo[4];
    assign inv_r1c2 = quo[5];
    assign inv_r2c0 = quo[6];
    assign inv_r2c1 = quo[7];
    assign inv_r2c2 = quo[8];

endmodule

`default_nettype wire

/* rtl/core/m3i_front.sv */
// Front part: products, cofactors, determinant and classification.
// Depends on m3i_pkg. Five pipeline stages, one matrix per cycle.
`default_nettype none

module m3i_front
    import m3i_pkg::*;
#(
    parameter int IN_WIDTH = IN_WIDTH_DEF
)
(
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire                                         accept,
    input  wire logic signed [IN_WIDTH-1:0]             a00,
    input  wire logic signed [IN_WIDTH-1:0]             a01,
    input  wire logic signed [IN_WIDTH-1:0]             a02,
    input  wire logic signed [IN_WIDTH-1:0]             a10,
    input  wire logic signed [IN_WIDTH-1:0]             a11,
    input  wire logic signed [IN_WIDTH-1:0]             a12,
    input  wire logic signed [IN_WIDTH-1:0]             a20,
    input  wire logic signed [IN_WIDTH-1:0]             a21,
    input  wire logic signed [IN_WIDTH-1:0]             a22,
    output job_ctl_t                                    ctl,
    output logic [8:0][m3i_cof_width(IN_WIDTH)-1:0]     cmag,
    output logic [8:0]                                  cneg,
    output logic [m3i_det_width(IN_WIDTH)-1:0]          dmag,
    output logic                                        dneg
);

    localparam int PW = 2 * IN_WIDTH;
    localparam int CW = m3i_cof_width(IN_WIDTH);
    localparam int TW = CW + IN_WIDTH;
    localparam int DW = m3i_det_width(IN_WIDTH);

    logic signed [IN_WIDTH-1:0] a [9];
    logic signed [PW-1:0]       p1_next [9];
    logic signed [PW-1:0]       p2_next [9];
    logic signed [PW-1:0]       p1_reg [9];
    logic signed [PW-1:0]       p2_reg [9];
    logic signed [CW-1:0]       c_reg [9];
    logic signed [CW-1:0]       c3_reg [9];
    logic signed [TW-1:0]       t_reg [3];
    logic signed [IN_WIDTH-1:0] row2_s1_reg [3];
    logic signed [IN_WIDTH-1:0] row2_s2_reg [3];
    logic signed [DW-1:0]       det_reg;
    logic [8:0][CW-1:0]         cmag4_reg;
    logic [8:0]                 cneg4_reg;
    logic [8:0][CW-1:0]         cmag_reg;
    logic [8:0]                 cneg_reg;
    logic [DW-1:0]              dmag_reg;
    logic                       dneg_reg;
    logic                       sing_reg;
    logic [4:0]                 vld_reg;

    assign a[0] = a00;
    assign a[1] = a01;
    assign a[2] = a02;
    assign a[3] = a10;
    assign a[4] = a11;
    assign a[5] = a12;
    assign a[6] = a20;
    assign a[7] = a21;
    assign a[8] = a22;

    // cofactor k = p1[k] - p2[k], already in transposed order
    always_comb
    begin
        p1_next[0] = a[4] * a[8];  p2_next[0] = a[5] * a[7];
        p1_next[1] = a[2] * a[7];  p2_next[1] = a[8] * a[1];
        p1_next[2] = a[1] * a[5];  p2_next[2] = a[2] * a[4];
        p1_next[3] = a[5] * a[6];  p2_next[3] = a[8] * a[3];
        p1_next[4] = a[0] * a[8];  p2_next[4] = a[2] * a[6];
        p1_next[5] = a[2] * a[3];  p2_next[5] = a[5] * a[0];
        p1_next[6] = a[3] * a[7];  p2_next[6] = a[4] * a[6];
        p1_next[7] = a[1] * a[6];  p2_next[7] = a[0] * a[7];
        p1_next[8] = a[0] * a[4];  p2_next[8] = a[1] * a[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            p1_reg[k] <= p1_next[k];
            p2_reg[k] <= p2_next[k];
            c_reg[k]  <= $signed({p1_reg[k][PW-1], p1_reg[k]})
                       - $signed({p2_reg[k][PW-1], p2_reg[k]});
            c3_reg[k] <= c_reg[k];
            cneg4_reg[k] <= c3_reg[k][CW-1];
            cmag4_reg[k] <= c3_reg[k][CW-1] ? CW'(-c3_reg[k]) : CW'(c3_reg[k]);
        end
        for (int j = 0; j < 3; j++)
        begin
            row2_s1_reg[j] <= a[6 + j];
            row2_s2_reg[j] <= row2_s1_reg[j];
        end
        // expand along the bottom row
        t_reg[0] <= c_reg[8] * row2_s2_reg[2];
        t_reg[1] <= c_reg[5] * row2_s2_reg[1];
        t_reg[2] <= c_reg[2] * row2_s2_reg[0];
        det_reg  <= DW'(t_reg[0]) + DW'(t_reg[1]) + DW'(t_reg[2]);
        cmag_reg <= cmag4_reg;
        cneg_reg <= cneg4_reg;
        dneg_reg <= det_reg[DW-1];
        dmag_reg <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
        sing_reg <= (det_reg == '0);
    end

    assign ctl.valid    = vld_reg[4];
    assign ctl.singular = sing_reg;
    assign cmag         = cmag_reg;
    assign cneg         = cneg_reg;
    assign dmag         = dmag_reg;
    assign dneg         = dneg_reg;

endmodule

`default_nettype wire

/* rtl/core/m3i_queue.sv */
// Short queue between front and back; drains one transaction per cycle.
// Depends on m3i_pkg.
`default_nettype none

module m3i_queue
    import m3i_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    input  wire  [WIDTH-1:0] in_data,
    output logic             full,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             push, pop;

    assign full      = (cnt_reg == CNTW'(DEPTH));
    assign push      = in_valid && !full;
    assign pop       = (cnt_reg != '0);
    assign out_valid = pop;
    assign out_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNTW'(push) - CNTW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/m3i_div.sv */
// Back part: one pipelined restoring divider, one quotient bit per stage,
// rounding to nearest and saturating. Depends on m3i_pkg.
`default_nettype none

module m3i_div
    import m3i_pkg::*;
#(
    parameter int CW        = 33,
    parameter int DW        = 51,
    parameter int OUT_WIDTH = OUT_WIDTH_DEF
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire job_ctl_t        in_ctl,
    input  wire  [CW-1:0]        cmag,
    input  wire  [DW-1:0]        dmag,
    input  wire                  neg,
    output job_ctl_t             out_ctl,
    output logic [OUT_WIDTH-1:0] quo
);

    localparam int QB   = OUT_WIDTH;
    localparam int NW   = CW + FRAC_SHIFT + 2;
    localparam int DENW = DW + 1;
    localparam int WW   = ((NW > DENW + QB) ? NW : DENW + QB) + 1;

    localparam logic [OUT_WIDTH-1:0] POS_LIM = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic [OUT_WIDTH-1:0] NEG_LIM = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    logic [WW-1:0]   rem_reg  [QB+1];
    logic [WW-1:0]   rem_next [QB+1];
    logic [DENW-1:0] den_reg  [QB+1];
    logic [QB-1:0]   q_reg    [QB+1];
    logic [QB-1:0]   q_next   [QB+1];
    logic            ov_reg   [QB+1];
    logic            ov_next  [QB+1];
    logic            neg_reg  [QB+1];
    logic            vld_reg  [QB+1];
    logic            sing_reg [QB+1];
    logic [OUT_WIDTH-1:0] quo_reg, quo_next;
    logic            out_vld_reg, out_sing_reg;

    // round to nearest: (2n + d) / (2d)
    assign rem_next[0] = (WW'(cmag) << (FRAC_SHIFT + 1)) + WW'(dmag);
    assign q_next[0]   = '0;
    assign ov_next[0]  = 1'b0;

    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        localparam int BIT = QB - 1 - k;
        logic [WW-1:0] shd;
        logic          ge;

        assign shd           = WW'(den_reg[k]) << BIT;
        assign ge            = (rem_reg[k] >= shd);
        assign rem_next[k+1] = ge ? rem_reg[k] - shd : rem_reg[k];
        assign q_next[k+1]   = q_reg[k] | (ge ? (QB'(1) << BIT) : '0);
        if (k == 0)
        begin : g_ovf
            // quotient would not fit in QB bits
            assign ov_next[k+1] = (rem_reg[0] >= (WW'(den_reg[0]) << QB));
        end
        else
        begin : g_hold
            assign ov_next[k+1] = ov_reg[k];
        end
    end

    always_comb
    begin
        if (sing_reg[QB])
        begin
            quo_next = '0;
        end
        else if (neg_reg[QB])
        begin
            quo_next = (ov_reg[QB] || (q_reg[QB] > NEG_LIM)) ? NEG_LIM : '0 - q_reg[QB];
        end
        else
        begin
            quo_next = (ov_reg[QB] || (q_reg[QB] > POS_LIM)) ? POS_LIM : q_reg[QB];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= QB; i++)
            begin
                vld_reg[i]  <= 1'b0;
                sing_reg[i] <= 1'b0;
            end
            out_vld_reg  <= 1'b0;
            out_sing_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0]  <= in_ctl.valid;
            sing_reg[0] <= in_ctl.singular;
            for (int i = 1; i <= QB; i++)
            begin
                vld_reg[i]  <= vld_reg[i-1];
                sing_reg[i] <= sing_reg[i-1];
            end
            out_vld_reg  <= vld_reg[QB];
            out_sing_reg <= sing_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg[0] <= {dmag, 1'b0};
        neg_reg[0] <= neg;
        for (int i = 0; i <= QB; i++)
        begin
            rem_reg[i] <= rem_next[i];
            q_reg[i]   <= q_next[i];
            ov_reg[i]  <= ov_next[i];
        end
        for (int i = 1; i <= QB; i++)
        begin
            den_reg[i] <= den_reg[i-1];
            neg_reg[i] <= neg_reg[i-1];
        end
        quo_reg <= quo_next;
    end

    assign out_ctl.valid    = out_vld_reg;
    assign out_ctl.singular = out_sing_reg;
    assign quo              = quo_reg;

endmodule

`default_nettype wire

/* rtl/core/m3i_checker.sv */
// Port-level checks for matrix3_inverse_top, attached by bind.
// Depends on m3i_pkg.
`default_nettype none

module m3i_checker
    import m3i_pkg::*;
#(
    parameter int OUT_WIDTH = OUT_WIDTH_DEF
)
(
    input wire                 clk,
    input wire                 rst_n,
    input wire                 start,
    input wire                 busy,
    input wire                 done,
    input wire [OUT_WIDTH-1:0] inv_r0c0,
    input wire [OUT_WIDTH-1:0] inv_r0c1,
    input wire [OUT_WIDTH-1:0] inv_r0c2,
    input wire [OUT_WIDTH-1:0] inv_r1c0,
    input wire [OUT_WIDTH-1:0] inv_r1c1,
    input wire [OUT_WIDTH-1:0] inv_r1c2,
    input wire [OUT_WIDTH-1:0] inv_r2c0,
    input wire [OUT_WIDTH-1:0] inv_r2c1,
    input wire [OUT_WIDTH-1:0] inv_r2c2,
    input wire                 singular
);

    localparam int LAT = m3i_latency(OUT_WIDTH);

    // every accepted transaction comes out after the fixed latency
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted transaction did not complete on time");

    // no result without a matching transaction
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without accepted transaction");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && singular) |-> (inv_r0c0 == '0 && inv_r0c1 == '0 && inv_r0c2 == '0
            && inv_r1c0 == '0 && inv_r1c1 == '0 && inv_r1c2 == '0
            && inv_r2c0 == '0 && inv_r2c1 == '0 && inv_r2c2 == '0))
        else $error("singular result with nonzero entries");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !done)
        else $error("done raised out of reset");

endmodule

bind matrix3_inverse_top m3i_checker #(.OUT_WIDTH(OUT_WIDTH)) u_m3i_checker (.*);

`default_nettype wire
